>>> src/ata_chs_task_file_issuer_defines.svh
// Assertion macros shared by the task-file issuer RTL.
// Used by files that carry concurrent checks; needs i_clk and i_rst_n in scope.
`ifndef ATA_CHS_TASK_FILE_ISSUER_DEFINES_SVH
`define ATA_CHS_TASK_FILE_ISSUER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ACTI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ACTI_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/acti_pkg.sv
// Package for the task-file issuer: codes, widths and the item record.
// No dependencies.
`timescale 1ns / 1ps
package acti_pkg;

    localparam int unsigned HEADS_W = 5;
    localparam int unsigned SPT_W   = 8;
    localparam int unsigned LBA_W   = 32;
    localparam int unsigned CNT_W   = 8;
    localparam int unsigned CYL_W   = 16;
    localparam int unsigned SPC_W   = HEADS_W + SPT_W;
    localparam int unsigned CFG_W   = 8;
    localparam int unsigned CFG_IDX_W = 2;

    typedef enum logic [2:0] {
        CMD_READ     = 3'd0,
        CMD_WRITE    = 3'd1,
        CMD_IDENTIFY = 3'd2,
        CMD_RECAL    = 3'd3,
        CMD_DIAG     = 3'd4,
        CMD_INIT     = 3'd5,
        CMD_SETMULT  = 3'd6
    } t_cmd;

    typedef enum logic [2:0] {
        SEL_CYL_LO  = 3'd0,
        SEL_CYL_HI  = 3'd1,
        SEL_DRVHEAD = 3'd2,
        SEL_SECTOR  = 3'd3,
        SEL_COUNT   = 3'd4,
        SEL_CONTROL = 3'd5,
        SEL_COMMAND = 3'd6
    } t_sel;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEADS0 = 2'd0,
        CFG_SPT0   = 2'd1,
        CFG_HEADS1 = 2'd2,
        CFG_SPT1   = 2'd3
    } t_cfg_idx;

    localparam logic [7:0] OP_READ      = 8'h20;
    localparam logic [7:0] OP_WRITE     = 8'h30;
    localparam logic [7:0] OP_IDENTIFY  = 8'hec;
    localparam logic [7:0] OP_RECAL     = 8'h10;
    localparam logic [7:0] OP_DIAG      = 8'h90;
    localparam logic [7:0] OP_INIT      = 8'h91;
    localparam logic [7:0] OP_SETMULT   = 8'hc6;
    localparam logic [7:0] DH_FIXED     = 8'ha0;

    // Command attributes that ride along the divider chain.
    typedef struct packed {
        t_cmd               cmd;
        logic               dev;
        logic [CNT_W-1:0]   cnt;
        logic [HEADS_W-1:0] heads;
        logic [SPT_W-1:0]   spt;
    } t_side;

    // Fully resolved command handed to the beat sequencer.
    typedef struct packed {
        t_side              side;
        logic [CYL_W-1:0]   cyl;
        logic [7:0]         head;
        logic [7:0]         sector;
    } t_item;

endpackage

>>> src/acti_div_cell.sv
// One restoring-division step with its pipeline register.
// Stand-alone; chained by the top level into divider rows.
`timescale 1ns / 1ps
module acti_div_cell #(
    parameter int unsigned N = 32,
    parameter int unsigned D = 13,
    parameter int unsigned S = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_adv,
    input  logic         i_valid,
    input  logic [D-1:0] i_rem,
    input  logic [N-1:0] i_num,
    input  logic [D-1:0] i_div,
    input  logic [S-1:0] i_side,
    output logic         o_valid,
    output logic [D-1:0] o_rem,
    output logic [N-1:0] o_num,
    output logic [D-1:0] o_div,
    output logic [S-1:0] o_side
);
    logic [D:0]   w_part;
    logic [D+1:0] w_diff;
    logic         w_ge;
    logic         r_valid;
    logic [D-1:0] r_rem, n_rem;
    logic [N-1:0] r_num, n_num;
    logic [D-1:0] r_div;
    logic [S-1:0] r_side;

    assign w_part = {i_rem, i_num[N-1]};
    assign w_diff = {1'b0, w_part} - {2'b00, i_div};
    assign w_ge   = !w_diff[D+1];
    assign n_rem  = w_ge ? w_diff[D-1:0] : w_part[D-1:0];
    assign n_num  = {i_num[N-2:0], w_ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rem  <= n_rem;
            r_num  <= n_num;
            r_div  <= i_div;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_num   = r_num;
    assign o_div   = r_div;
    assign o_side  = r_side;
endmodule

>>> src/acti_emitter.sv
// Beat sequencer: turns one resolved command into its task-file writes.
// Depends on acti_pkg.
`timescale 1ns / 1ps
module acti_emitter (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_item_valid,
    input  acti_pkg::t_item i_item,
    output logic           o_ready,
    input  logic           i_stall,
    output logic           o_valid,
    output logic [2:0]     o_reg_select,
    output logic [7:0]     o_reg_value,
    output logic           o_last
);
    import acti_pkg::*;

    logic       r_busy;
    logic [2:0] r_step;
    t_item      r_item;
    logic       r_out_valid;
    t_sel       r_out_sel;
    logic [7:0] r_out_value;
    logic       r_out_last;

    t_sel       w_sel;
    logic [7:0] w_value;
    logic [7:0] w_dh;
    logic       w_is_last;
    logic       w_load;
    logic       w_take;

    always_comb begin
        w_sel = SEL_COMMAND;
        case (r_item.side.cmd)
            CMD_READ, CMD_WRITE: w_sel = t_sel'(r_step);
            CMD_INIT, CMD_SETMULT: begin
                case (r_step)
                    3'd0:    w_sel = SEL_DRVHEAD;
                    3'd1:    w_sel = SEL_COUNT;
                    3'd2:    w_sel = SEL_CONTROL;
                    default: w_sel = SEL_COMMAND;
                endcase
            end
            default: begin
                case (r_step)
                    3'd0:    w_sel = SEL_DRVHEAD;
                    3'd1:    w_sel = SEL_CONTROL;
                    default: w_sel = SEL_COMMAND;
                endcase
            end
        endcase
    end

    assign w_dh = DH_FIXED | {3'b000, r_item.side.dev, 4'b0000};

    always_comb begin
        w_value = 8'h00;
        unique case (w_sel)
            SEL_CYL_LO:  w_value = r_item.cyl[7:0];
            SEL_CYL_HI:  w_value = r_item.cyl[15:8];
            SEL_DRVHEAD: begin
                case (r_item.side.cmd)
                    CMD_READ, CMD_WRITE: w_value = w_dh | r_item.head;
                    CMD_DIAG:            w_value = DH_FIXED;
                    CMD_INIT:            w_value = w_dh |
                                             {3'b000, r_item.side.heads - 5'd1};
                    default:             w_value = w_dh;
                endcase
            end
            SEL_SECTOR:  w_value = r_item.sector;
            SEL_COUNT:   w_value = (r_item.side.cmd == CMD_INIT) ? r_item.side.spt
                                                                 : r_item.side.cnt;
            SEL_CONTROL: w_value = 8'h00;
            SEL_COMMAND: begin
                case (r_item.side.cmd)
                    CMD_READ:     w_value = OP_READ;
                    CMD_WRITE:    w_value = OP_WRITE;
                    CMD_IDENTIFY: w_value = OP_IDENTIFY;
                    CMD_RECAL:    w_value = OP_RECAL;
                    CMD_DIAG:     w_value = OP_DIAG;
                    CMD_INIT:     w_value = OP_INIT;
                    default:      w_value = OP_SETMULT;
                endcase
            end
            default:     w_value = 8'h00;
        endcase
    end

    assign w_is_last = (w_sel == SEL_COMMAND);
    assign w_load    = !r_out_valid || !i_stall;
    assign o_ready   = !r_busy || (w_load && w_is_last);
    assign w_take    = i_item_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= r_busy;
            end
            if (w_take) begin
                r_busy <= 1'b1;
                r_step <= 3'd0;
            end else if (r_busy && w_load) begin
                r_busy <= !w_is_last;
                r_step <= r_step + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= i_item;
        end
        if (w_load) begin
            r_out_sel   <= w_sel;
            r_out_value <= w_value;
            r_out_last  <= w_is_last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_reg_select = r_out_sel;
    assign o_reg_value  = r_out_value;
    assign o_last       = r_out_last;
endmodule

>>> src/ata_chs_task_file_issuer.sv
// Top level of the ATA CHS task-file issuer.
// Depends on acti_pkg, acti_div_cell, acti_emitter and the assertion header.
`timescale 1ns / 1ps
// Usage
// The input channel takes one drive command per beat (cmd, device, lba, count);
// the output channel gives the task-file register writes that issue it, one
// beat per write, with o_last set on the closing command register write.
// Read and write give seven beats, init drive and set multiple four, identify,
// recalibrate and diagnostic three. Code 7 is accepted and gives nothing.
// A command passes a row of 32 division cells (lba by heads times sectors per
// track), then a row of 13 cells (remainder by sectors per track), each cell
// a register, ahead of the sequencer. The cell rows hold up to 45 commands at
// once and take a new one in every cycle while not stopped; sustained
// throughput is set by the sequencer at the end, which gives one beat per
// cycle while the receiver does not stall. When the receiver stalls, the
// output register holds its beat, the sequencer stops, and once the last cell
// holds a waiting command both cell rows stop and o_stall rises. Reset clears
// all valid flags and restores the geometry registers to 16 heads and 63
// sectors per track for both drives. The user must write geometry only while
// the block is idle; the block itself does not enforce it. Zero counts as one.
module ata_chs_task_file_issuer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [acti_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [acti_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [2:0]                          i_cmd,
    input  logic                                i_device,
    input  logic [acti_pkg::LBA_W-1:0]          i_lba,
    input  logic [acti_pkg::CNT_W-1:0]          i_count,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [2:0]                          o_reg_select,
    output logic [7:0]                          o_reg_value,
    output logic                                o_last
);
    import acti_pkg::*;
`include "ata_chs_task_file_issuer_defines.svh"

    localparam int unsigned S1_W = $bits(t_side);
    localparam int unsigned S2_W = $bits(t_side) + CYL_W;

    // Geometry registers.
    logic [HEADS_W-1:0] r_heads0, r_heads1;
    logic [SPT_W-1:0]   r_spt0, r_spt1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heads0 <= HEADS_W'(16);
            r_spt0   <= SPT_W'(63);
            r_heads1 <= HEADS_W'(16);
            r_spt1   <= SPT_W'(63);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_HEADS0: r_heads0 <= i_cfg_data[HEADS_W-1:0];
                CFG_SPT0:   r_spt0   <= i_cfg_data[SPT_W-1:0];
                CFG_HEADS1: r_heads1 <= i_cfg_data[HEADS_W-1:0];
                CFG_SPT1:   r_spt1   <= i_cfg_data[SPT_W-1:0];
                default:    ;
            endcase
        end
    end

    // Entry: pick the drive's geometry, treat zero as one, form the
    // sectors-per-cylinder divisor.
    logic [HEADS_W-1:0] w_heads_raw, w_heads;
    logic [SPT_W-1:0]   w_spt_raw, w_spt;
    logic [SPC_W-1:0]   w_spc;
    t_side              w_side_in;
    logic               w_adv;
    logic               w_cmd_ok;

    assign w_heads_raw = i_device ? r_heads1 : r_heads0;
    assign w_spt_raw   = i_device ? r_spt1 : r_spt0;
    assign w_heads     = (w_heads_raw == '0) ? HEADS_W'(1) : w_heads_raw;
    assign w_spt       = (w_spt_raw == '0) ? SPT_W'(1) : w_spt_raw;
    assign w_spc       = SPC_W'(w_heads) * SPC_W'(w_spt);
    assign w_cmd_ok    = (i_cmd <= 3'(CMD_SETMULT));

    assign w_side_in.cmd   = t_cmd'(i_cmd);
    assign w_side_in.dev   = i_device;
    assign w_side_in.cnt   = i_count;
    assign w_side_in.heads = w_heads;
    assign w_side_in.spt   = w_spt;

    // First row: lba divided by sectors per cylinder.
    logic               c1_valid [LBA_W+1];
    logic [SPC_W-1:0]   c1_rem   [LBA_W+1];
    logic [LBA_W-1:0]   c1_num   [LBA_W+1];
    logic [SPC_W-1:0]   c1_div   [LBA_W+1];
    logic [S1_W-1:0]    c1_side  [LBA_W+1];

    assign c1_valid[0] = i_valid && w_cmd_ok;
    assign c1_rem[0]   = '0;
    assign c1_num[0]   = i_lba;
    assign c1_div[0]   = w_spc;
    assign c1_side[0]  = w_side_in;

    for (genvar g = 0; g < LBA_W; g++) begin : g_row1
        acti_div_cell #(.N(LBA_W), .D(SPC_W), .S(S1_W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_valid (c1_valid[g]),
            .i_rem   (c1_rem[g]),
            .i_num   (c1_num[g]),
            .i_div   (c1_div[g]),
            .i_side  (c1_side[g]),
            .o_valid (c1_valid[g+1]),
            .o_rem   (c1_rem[g+1]),
            .o_num   (c1_num[g+1]),
            .o_div   (c1_div[g+1]),
            .o_side  (c1_side[g+1])
        );
    end

    // Second row: remainder divided by sectors per track gives head and
    // zero-based sector. The cylinder rides along, cut to 16 bits.
    t_side w_side1;
    assign w_side1 = t_side'(c1_side[LBA_W]);

    logic               c2_valid [SPC_W+1];
    logic [SPT_W-1:0]   c2_rem   [SPC_W+1];
    logic [SPC_W-1:0]   c2_num   [SPC_W+1];
    logic [SPT_W-1:0]   c2_div   [SPC_W+1];
    logic [S2_W-1:0]    c2_side  [SPC_W+1];

    assign c2_valid[0] = c1_valid[LBA_W];
    assign c2_rem[0]   = '0;
    assign c2_num[0]   = c1_rem[LBA_W];
    assign c2_div[0]   = w_side1.spt;
    assign c2_side[0]  = {c1_side[LBA_W], c1_num[LBA_W][CYL_W-1:0]};

    for (genvar g = 0; g < SPC_W; g++) begin : g_row2
        acti_div_cell #(.N(SPC_W), .D(SPT_W), .S(S2_W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_valid (c2_valid[g]),
            .i_rem   (c2_rem[g]),
            .i_num   (c2_num[g]),
            .i_div   (c2_div[g]),
            .i_side  (c2_side[g]),
            .o_valid (c2_valid[g+1]),
            .o_rem   (c2_rem[g+1]),
            .o_num   (c2_num[g+1]),
            .o_div   (c2_div[g+1]),
            .o_side  (c2_side[g+1])
        );
    end

    // Hand-off to the sequencer; the rows stop while it cannot take the
    // command in the last cell.
    t_item w_item;
    logic  w_emit_ready;

    assign w_item.side   = t_side'(c2_side[SPC_W][S2_W-1:CYL_W]);
    assign w_item.cyl    = c2_side[SPC_W][CYL_W-1:0];
    assign w_item.head   = c2_num[SPC_W][7:0];
    assign w_item.sector = c2_rem[SPC_W] + 8'd1;

    assign w_adv   = !c2_valid[SPC_W] || w_emit_ready;
    assign o_stall = !w_adv;

    acti_emitter u_emitter (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (c2_valid[SPC_W]),
        .i_item       (w_item),
        .o_ready      (w_emit_ready),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_reg_select (o_reg_select),
        .o_reg_value  (o_reg_value),
        .o_last       (o_last)
    );

    `ACTI_ASSERT_IMP(a_last_is_cmd, o_valid && o_last, o_reg_select == 3'(SEL_COMMAND), "last beat is not the command register write")
    `ACTI_ASSERT_IMP(a_cmd_is_last, o_valid && o_reg_select == 3'(SEL_COMMAND), o_last, "command register write without last")
    `ACTI_ASSERT_IMP(a_sector_nonzero, o_valid && o_reg_select == 3'(SEL_SECTOR), o_reg_value != 8'd0, "sector number zero")
    `ACTI_ASSERT_NXT(a_entry, i_valid && !o_stall && i_cmd != 3'd7, c1_valid[1], "accepted command lost at entry")
endmodule
